// ----- rtl/kfmr_pkg.sv -----
// Package for the keyed FIFO match-and-remove table.
// Holds sizing constants, operation codes and the record types.
// Used by every module of the block except the generic RAM.
package kfmr_pkg;

  // Table depth and derived widths
  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OCC_W   = 7;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int STAMP_W = 64;
  localparam int USER_W  = 32;
  localparam int PROC_W  = 23;

  // Operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] first;
    logic [KEY_W-1:0] second;
    logic [KEY_W-1:0] third;
  } key_t;

  typedef struct packed {
    key_t               key;
    logic [STAMP_W-1:0] stamp;
    logic [USER_W-1:0]  user;
    logic [PROC_W-1:0]  proc_id;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// ----- rtl/kfmr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module kfmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/kfmr_match.sv -----
// Key compare unit: checks one stored record against the search key.
// Depends on kfmr_pkg for the key and record types.
module kfmr_match import kfmr_pkg::*; (
  input  rec_t entry_i,
  input  key_t key_i,
  output logic hit_o
);

  // Match only when all three key words agree
  assign hit_o = (entry_i.key.first  == key_i.first)  &&
                 (entry_i.key.second == key_i.second) &&
                 (entry_i.key.third  == key_i.third);

endmodule

// ----- rtl/keyed_fifo_match_remove.sv -----
// Keyed FIFO match-and-remove table, records kept in arrival order by position.
// Append: done_o rises in the cycle after the accepting edge, as does find with no
//   records held; otherwise find runs SCAN and, after a removal, SHIFT, paced by the
//   one RAM read port that both scans positions and shifts younger records down.
// New transactions are taken only while busy_o is low; the receiver cannot stall.
// Reset (rst_ni low, asynchronous): table empty, sequencer idle; RAM not cleared.
module keyed_fifo_match_remove import kfmr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  input  logic                operation_i,
  input  logic [KEY_W-1:0]    key_first_i,
  input  logic [KEY_W-1:0]    key_second_i,
  input  logic [KEY_W-1:0]    key_third_i,
  input  logic [STAMP_W-1:0]  stamp_ns_i,
  input  logic [USER_W-1:0]   user_id_i,
  input  logic [PROC_W-1:0]   process_id_i,
  output logic                accepted_o,
  output logic                found_o,
  output logic [STAMP_W-1:0]  found_stamp_ns_o,
  output logic [USER_W-1:0]   found_user_id_o,
  output logic [PROC_W-1:0]   found_process_id_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  key_t               key_q, key_d;
  logic               acc_q, acc_d;
  logic               fnd_q, fnd_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [USER_W-1:0]  user_q, user_d;
  logic [PROC_W-1:0]  proc_q, proc_d;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  rec_t               wdata;
  logic [IDX_W-1:0]   raddr;
  rec_t               rdata;
  logic               hit;
  logic [CNT_W:0]     ptr_p1;
  logic [CNT_W:0]     ptr_p2;
  logic [CNT_W:0]     cnt_x;
  logic [CNT_W+OCC_W-1:0] occ_ext;
  rec_t               new_rec;

  assign ptr_p1 = {1'b0, ptr_q} + (CNT_W+1)'(1);
  assign ptr_p2 = {1'b0, ptr_q} + (CNT_W+1)'(2);
  assign cnt_x  = {1'b0, cnt_q};

  assign new_rec.key.first  = key_first_i;
  assign new_rec.key.second = key_second_i;
  assign new_rec.key.third  = key_third_i;
  assign new_rec.stamp      = stamp_ns_i;
  assign new_rec.user       = user_id_i;
  assign new_rec.proc_id    = process_id_i;

  // Record store, one entry per age position
  kfmr_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Compare the entry read last cycle against the held key
  kfmr_match u_match (
    .entry_i (rdata),
    .key_i   (key_q),
    .hit_o   (hit)
  );

  // Sequencer: append at the tail, or scan oldest first, then close the gap one position a cycle
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    key_d   = key_q;
    acc_d   = acc_q;
    fnd_d   = fnd_q;
    stamp_d = stamp_q;
    user_d  = user_q;
    proc_d  = proc_q;
    we      = 1'b0;
    waddr   = cnt_q[IDX_W-1:0];
    wdata   = new_rec;
    raddr   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d   = new_rec.key;
          acc_d   = 1'b0;
          fnd_d   = 1'b0;
          stamp_d = '0;
          user_d  = '0;
          proc_d  = '0;
          ptr_d   = '0;
          if (operation_i == OP_APPEND) begin
            state_d = ST_RESP;
            if (cnt_q < CNT_W'(ENTRIES)) begin
              we    = 1'b1;
              acc_d = 1'b1;
              cnt_d = cnt_q + CNT_W'(1);
            end
          end else if (cnt_q == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        raddr = ptr_p1[IDX_W-1:0];
        if (hit) begin
          fnd_d   = 1'b1;
          stamp_d = rdata.stamp;
          user_d  = rdata.user;
          proc_d  = rdata.proc_id;
          if (ptr_p1 < cnt_x) begin
            state_d = ST_SHIFT;
          end else begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = ST_RESP;
          end
        end else if (ptr_p1 < cnt_x) begin
          ptr_d = ptr_p1[CNT_W-1:0];
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SHIFT: begin
        // Move the record at ptr+1 down to ptr, fetch the next one
        we    = 1'b1;
        waddr = ptr_q[IDX_W-1:0];
        wdata = rdata;
        raddr = ptr_p2[IDX_W-1:0];
        if (ptr_p2 < cnt_x) begin
          ptr_d = ptr_p1[CNT_W-1:0];
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
    end
  end

  // Held key and result fields
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    acc_q   <= acc_d;
    fnd_q   <= fnd_d;
    stamp_q <= stamp_d;
    user_q  <= user_d;
    proc_q  <= proc_d;
  end

  assign occ_ext = {{OCC_W{1'b0}}, cnt_q};

  assign busy_o             = (state_q != ST_IDLE);
  assign done_o             = (state_q == ST_RESP);
  assign accepted_o         = acc_q;
  assign found_o            = fnd_q;
  assign found_stamp_ns_o   = stamp_q;
  assign found_user_id_o    = user_q;
  assign found_process_id_o = proc_q;
  assign occupancy_o        = occ_ext[OCC_W-1:0];

endmodule

// ----- rtl/kfmr_chk.sv -----
// Port-level checker for the keyed FIFO match-and-remove table, bound to the top.
// Depends on kfmr_pkg for field widths.
module kfmr_chk import kfmr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic               accepted_o,
  input logic               found_o,
  input logic [STAMP_W-1:0] found_stamp_ns_o,
  input logic [USER_W-1:0]  found_user_id_o,
  input logic [PROC_W-1:0]  found_process_id_o,
  input logic [OCC_W-1:0]   occupancy_o
);

  // An accepted transaction keeps the block busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepted transaction");

  // A result never reports both a stored append and a removal
  a_acc_found_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(accepted_o && found_o))
    else $error("accepted and found both set");

  // A result without a removal carries a zero payload
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (found_stamp_ns_o == '0 && found_user_id_o == '0 &&
                              found_process_id_o == '0))
    else $error("payload not zero without a match");

  // A stored append leaves at least one record held
  a_occ_after_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |-> (occupancy_o != '0))
    else $error("occupancy zero after a stored append");

endmodule

bind keyed_fifo_match_remove kfmr_chk u_kfmr_chk (.*);
